// ----- rtl/qoi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qoi_pkg;

    localparam int INDEX_ENTRIES = 64;
    localparam int INDEX_AW      = $clog2(INDEX_ENTRIES);
    localparam int PIXELS_W      = 29;
    localparam int RUN_W         = 6;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

    // result kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // chunk tags
    localparam logic [7:0] TAG_RGB  = 8'hFE;
    localparam logic [7:0] TAG_RGBA = 8'hFF;
    localparam logic [1:0] OP_INDEX = 2'b00;
    localparam logic [1:0] OP_DIFF  = 2'b01;
    localparam logic [1:0] OP_LUMA  = 2'b10;

    localparam logic [31:0] PIXEL_RESET = 32'h0000_00FF;
    localparam logic [3:0]  MARKER_LAST = 4'd7;

    typedef enum logic [1:0] {
        PH_DECODE   = 2'd0,
        PH_TRAILER  = 2'd1,
        PH_FINISHED = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CK_RGB  = 2'd0,
        CK_RGBA = 2'd1,
        CK_LUMA = 2'd2
    } chunk_kind_t;

    // one decoded byte's worth of work for the output side
    typedef struct packed {
        logic [31:0]      pixel;
        logic [RUN_W-1:0] count;
        logic             has_verdict;
        logic [1:0]       verdict;
    } cmd_t;

    // (3r + 5g + 7b + 11a) mod 64, only the low six bits matter
    function automatic logic [INDEX_AW-1:0] pixel_hash(input logic [31:0] px);
        logic [INDEX_AW-1:0] r3;
        logic [INDEX_AW-1:0] g5;
        logic [INDEX_AW-1:0] b7;
        logic [INDEX_AW-1:0] a11;
        r3  = INDEX_AW'(px[24 +: INDEX_AW] * 3);
        g5  = INDEX_AW'(px[16 +: INDEX_AW] * 5);
        b7  = INDEX_AW'(px[8 +: INDEX_AW] * 7);
        a11 = INDEX_AW'(px[0 +: INDEX_AW] * 11);
        return INDEX_AW'(r3 + g5 + b7 + a11);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/qoi_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qoi_front import qoi_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [PIXELS_W-1:0] total_pixels,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          data_byte,
    input  wire logic                start_of_image,
    input  wire logic                last_byte,
    input  wire logic                cmd_full,
    output logic                     cmd_valid,
    output cmd_t                     cmd
);

    // decode stage holding register
    logic       s2_valid_reg;
    logic [7:0] s2_byte_reg;
    logic       s2_sof_reg;
    logic       s2_last_reg;

    // decoder state
    logic [31:0]         wp_reg, wp_next;
    logic [PIXELS_W-1:0] done_reg, done_next;
    chunk_kind_t         ck_reg, ck_next;
    logic [2:0]          pend_reg, pend_next;
    logic [23:0]         partial_reg, partial_next;
    logic [3:0]          trail_reg, trail_next;
    phase_t              phase_reg, phase_next;

    // colour index with per-entry valid bits, cleared at image start
    logic [31:0]              idx_mem [INDEX_ENTRIES];
    logic [31:0]              mem_q_reg;
    logic [INDEX_ENTRIES-1:0] ivalid_reg, ivalid_next;
    logic                     rd_valid_reg;
    logic                     fwd_hit_reg;
    logic [31:0]              fwd_data_reg;

    logic                s2_fire;
    logic                accept;
    logic                finish;
    logic [INDEX_AW-1:0] wr_addr;
    logic                wr_en;
    logic [RUN_W-1:0]    cnt_req;
    logic [RUN_W-1:0]    clipped;
    logic                verdict_en;
    logic [1:0]          verdict;

    // effective state after an optional restart
    logic [31:0]         eff_wp;
    logic [PIXELS_W-1:0] eff_done;
    chunk_kind_t         eff_ck;
    logic [2:0]          eff_pend;
    logic [23:0]         eff_partial;
    logic [31:0]         idx_val;
    logic [PIXELS_W:0]   left_diff;
    logic [PIXELS_W-1:0] left_sat;
    phase_t              ph;
    logic [3:0]          tc;
    logic [7:0]          b;
    logic [7:0]          dg;
    logic [2:0]          pend_dec;
    logic [7:0]          want;

    assign s2_fire  = s2_valid_reg && !cmd_full;
    assign in_ready = !s2_valid_reg || s2_fire;
    assign accept   = in_valid && in_ready;
    assign wr_en    = s2_fire && finish;
    assign wr_addr  = pixel_hash(wp_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s2_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_byte_reg <= data_byte;
            s2_sof_reg  <= start_of_image;
            s2_last_reg <= last_byte;
        end
    end

    // index memory: read old data on the accept edge, forward a same-edge write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            idx_mem[wr_addr] <= wp_next;
        end
        if (accept)
        begin
            mem_q_reg    <= idx_mem[data_byte[INDEX_AW-1:0]];
            fwd_hit_reg  <= wr_en && (wr_addr == data_byte[INDEX_AW-1:0]);
            fwd_data_reg <= wp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rd_valid_reg <= ivalid_next[data_byte[INDEX_AW-1:0]];
        end
    end

    always_comb
    begin
        ivalid_next = ivalid_reg;
        if (s2_fire && s2_sof_reg)
        begin
            ivalid_next = '0;
        end
        if (wr_en)
        begin
            ivalid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg  <= '0;
            wp_reg      <= PIXEL_RESET;
            done_reg    <= '0;
            ck_reg      <= CK_RGB;
            pend_reg    <= '0;
            partial_reg <= '0;
            trail_reg   <= '0;
            phase_reg   <= PH_DECODE;
        end
        else
        begin
            ivalid_reg <= ivalid_next;
            if (s2_fire)
            begin
                wp_reg      <= wp_next;
                done_reg    <= done_next;
                ck_reg      <= ck_next;
                pend_reg    <= pend_next;
                partial_reg <= partial_next;
                trail_reg   <= trail_next;
                phase_reg   <= phase_next;
            end
        end
    end

    always_comb
    begin
        b           = s2_byte_reg;
        eff_wp      = s2_sof_reg ? PIXEL_RESET : wp_reg;
        eff_done    = s2_sof_reg ? '0 : done_reg;
        eff_ck      = s2_sof_reg ? CK_RGB : ck_reg;
        eff_pend    = s2_sof_reg ? 3'd0 : pend_reg;
        eff_partial = s2_sof_reg ? 24'd0 : partial_reg;
        ph          = s2_sof_reg ? PH_DECODE : phase_reg;
        tc          = s2_sof_reg ? 4'd0 : trail_reg;

        if (s2_sof_reg)
        begin
            idx_val = '0;
        end
        else if (fwd_hit_reg)
        begin
            idx_val = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            idx_val = mem_q_reg;
        end
        else
        begin
            idx_val = '0;
        end

        left_diff = {1'b0, total_pixels} - {1'b0, eff_done};
        left_sat  = left_diff[PIXELS_W] ? '0 : left_diff[PIXELS_W-1:0];

        // nothing pending and image already full: byte belongs to the end marker
        if (ph == PH_DECODE && eff_pend == 3'd0 && left_sat == '0)
        begin
            ph = PH_TRAILER;
            tc = 4'd0;
        end

        wp_next      = eff_wp;
        ck_next      = eff_ck;
        pend_next    = eff_pend;
        partial_next = eff_partial;
        trail_next   = tc;
        phase_next   = ph;
        finish       = 1'b0;
        cnt_req      = '0;
        verdict_en   = 1'b0;
        verdict      = KIND_ERROR;
        dg           = {2'b00, eff_partial[5:0]};
        pend_dec     = eff_pend - 3'd1;
        want         = (tc < MARKER_LAST) ? 8'd0 : 8'd1;

        case (ph)
            PH_DECODE:
            begin
                if (eff_pend != 3'd0)
                begin
                    if (eff_ck == CK_LUMA)
                    begin
                        pend_next = 3'd0;
                        wp_next   = {8'(eff_wp[31:24] + dg - 8'd32 + {4'd0, b[7:4]} - 8'd8),
                                     8'(eff_wp[23:16] + dg - 8'd32),
                                     8'(eff_wp[15:8] + dg - 8'd32 + {4'd0, b[3:0]} - 8'd8),
                                     eff_wp[7:0]};
                        finish    = 1'b1;
                    end
                    else if (eff_ck == CK_RGBA && eff_pend == 3'd1)
                    begin
                        pend_next = 3'd0;
                        wp_next   = {eff_partial, b};
                        finish    = 1'b1;
                    end
                    else
                    begin
                        partial_next = {eff_partial[15:0], b};
                        pend_next    = pend_dec;
                        if (pend_dec == 3'd0)
                        begin
                            wp_next = {eff_partial[15:0], b, eff_wp[7:0]};
                            finish  = 1'b1;
                        end
                    end
                end
                else if (b == TAG_RGB)
                begin
                    ck_next      = CK_RGB;
                    pend_next    = 3'd3;
                    partial_next = '0;
                end
                else if (b == TAG_RGBA)
                begin
                    ck_next      = CK_RGBA;
                    pend_next    = 3'd4;
                    partial_next = '0;
                end
                else if (b[7:6] == OP_INDEX)
                begin
                    wp_next = idx_val;
                    finish  = 1'b1;
                end
                else if (b[7:6] == OP_DIFF)
                begin
                    wp_next = {8'(eff_wp[31:24] + {6'd0, b[5:4]} - 8'd2),
                               8'(eff_wp[23:16] + {6'd0, b[3:2]} - 8'd2),
                               8'(eff_wp[15:8] + {6'd0, b[1:0]} - 8'd2),
                               eff_wp[7:0]};
                    finish  = 1'b1;
                end
                else if (b[7:6] == OP_LUMA)
                begin
                    ck_next      = CK_LUMA;
                    pend_next    = 3'd1;
                    partial_next = {18'd0, b[5:0]};
                end
                else
                begin
                    finish = 1'b1;
                end

                if (finish)
                begin
                    // a run tag is at most 0xFD, so the length fits in six bits
                    cnt_req = (eff_pend == 3'd0 && b[7:6] == 2'b11)
                              ? RUN_W'(b[5:0] + 6'd1) : RUN_W'(1);
                end
            end
            PH_TRAILER:
            begin
                if (b != want)
                begin
                    verdict_en = 1'b1;
                    phase_next = PH_FINISHED;
                end
                else if (tc >= MARKER_LAST)
                begin
                    verdict_en = 1'b1;
                    verdict    = s2_last_reg ? KIND_OK : KIND_ERROR;
                    phase_next = PH_FINISHED;
                end
                else if (s2_last_reg)
                begin
                    verdict_en = 1'b1;
                    phase_next = PH_FINISHED;
                end
                else
                begin
                    trail_next = tc + 4'd1;
                end
            end
            default:
            begin
            end
        endcase

        // clip to the pixels that remain
        if (left_sat[PIXELS_W-1:RUN_W] == '0 && left_sat[RUN_W-1:0] < cnt_req)
        begin
            clipped = left_sat[RUN_W-1:0];
        end
        else
        begin
            clipped = cnt_req;
        end
        done_next = eff_done + PIXELS_W'(clipped);

        if (ph == PH_DECODE)
        begin
            if (pend_next == 3'd0 && left_sat == PIXELS_W'(clipped))
            begin
                phase_next = PH_TRAILER;
                trail_next = 4'd0;
            end
            if (s2_last_reg)
            begin
                verdict_en = 1'b1;
                verdict    = KIND_ERROR;
                phase_next = PH_FINISHED;
            end
        end
    end

    always_comb
    begin
        cmd_valid       = s2_fire && (clipped != '0 || verdict_en);
        cmd.pixel       = wp_next;
        cmd.count       = clipped;
        cmd.has_verdict = verdict_en;
        cmd.verdict     = verdict;
    end

endmodule

`default_nettype wire

// ----- rtl/qoi_cmd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qoi_cmd_fifo import qoi_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    input  wire cmd_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output logic      empty,
    output cmd_t      rd_data
);

    cmd_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg;
    logic [FIFO_AW-1:0] rptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_wr;
    logic               do_rd;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_valid && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + FIFO_AW'(1);
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + FIFO_AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + (FIFO_AW+1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - (FIFO_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/qoi_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qoi_back import qoi_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_empty,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    input  wire logic pop,
    output logic      empty,
    output logic [1:0] kind,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    output logic [7:0] alpha,
    output logic       last_of_run
);

    logic             out_valid_reg;
    logic [1:0]       kind_reg;
    logic [31:0]      px_reg;
    logic             last_reg;
    logic [RUN_W-1:0] sent_reg;

    logic             load;
    logic             is_pixel;
    logic             gen_last;
    logic [RUN_W-1:0] sent_inc;

    assign sent_inc = sent_reg + RUN_W'(1);
    assign is_pixel = (sent_reg != cmd.count);
    assign gen_last = is_pixel ? (sent_inc == cmd.count && !cmd.has_verdict) : 1'b1;
    assign load     = !cmd_empty && (!out_valid_reg || pop);
    assign cmd_pop  = load && gen_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sent_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load)
            begin
                sent_reg <= gen_last ? '0 : sent_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= is_pixel ? KIND_PIXEL : cmd.verdict;
            px_reg   <= is_pixel ? cmd.pixel : 32'd0;
            last_reg <= gen_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign kind        = kind_reg;
    assign red         = px_reg[31:24];
    assign green       = px_reg[23:16];
    assign blue        = px_reg[15:8];
    assign alpha       = px_reg[7:0];
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

// ----- rtl/qoi_image_decoder.sv -----
// QOI chunk-stream decoder, header already stripped.
// Input queue: data_byte, start_of_image and last_byte move on a transfer
// when push is high and full is low. start_of_image restarts decoding on that
// byte: colour index cleared, working pixel opaque black, counters zeroed.
// Result queue: while empty is low the oldest result (kind, red, green, blue,
// alpha, last_of_run) is on the ports; a transfer happens when pop is high.
// kind 0 is a pixel, 1 end marker ok, 2 format error; last_of_run flags the
// final result from one input byte.
// Configuration: cfg_data (pixel total) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Throughput: one byte per cycle into the decode stage; the output side
// gives one result per cycle while pop is high, so a run of n pixels
// holds the output for n results; input stalls once the 4-entry command queue fills.
// A result passes the decode register, command queue and output register.
// When pop is held low, results wait in the output register and queue, and
// full rises. Reset clears the index valid bits at once: no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module qoi_image_decoder import qoi_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [7:0]          data_byte,
    input  wire logic                start_of_image,
    input  wire logic                last_byte,
    input  wire logic                pop,
    output logic                     empty,
    output logic [1:0]               kind,
    output logic [7:0]               red,
    output logic [7:0]               green,
    output logic [7:0]               blue,
    output logic [7:0]               alpha,
    output logic                     last_of_run,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [PIXELS_W-1:0] cfg_data
);

    logic [PIXELS_W-1:0] total_reg;
    logic                in_ready;
    logic                cmd_valid;
    cmd_t                cmd_in;
    logic                cmd_full;
    logic                cmd_empty;
    logic                cmd_pop;
    cmd_t                cmd_head;

    assign cfg_ready = 1'b1;
    assign full      = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= PIXELS_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            total_reg <= cfg_data;
        end
    end

    qoi_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .total_pixels   (total_reg),
        .in_valid       (push),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .start_of_image (start_of_image),
        .last_byte      (last_byte),
        .cmd_full       (cmd_full),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd_in)
    );

    qoi_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cmd_valid),
        .wr_data  (cmd_in),
        .full     (cmd_full),
        .rd_en    (cmd_pop),
        .empty    (cmd_empty),
        .rd_data  (cmd_head)
    );

    qoi_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (cmd_empty),
        .cmd         (cmd_head),
        .cmd_pop     (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .kind        (kind),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

// ----- test/qoi_decode_checker.sv -----
`timescale 1ns / 1ps

module qoi_decode_checker import qoi_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  logic [7:0]          data_byte,
    input  logic                start_of_image,
    input  logic                last_byte,
    input  logic                pop,
    input  logic                empty,
    input  logic [1:0]          kind,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    input  logic [7:0]          alpha,
    input  logic                last_of_run,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [PIXELS_W-1:0] cfg_data,
    output int                  fail_count,
    output int                  outstanding
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } decoder_out_t;

    // decoder state as the stream should leave it
    logic [PIXELS_W-1:0] pixel_total;
    logic [31:0]         cur_px;
    logic [31:0]         colour_tbl [INDEX_ENTRIES];
    logic [PIXELS_W-1:0] px_done;
    chunk_kind_t         chunk;
    logic [2:0]          bytes_left;
    logic [23:0]         held;
    logic [3:0]          marker_pos;
    phase_t              stage;

    decoder_out_t awaited [$];
    decoder_out_t byte_results [$];

    function automatic void restart_image();
        cur_px = PIXEL_RESET;
        foreach (colour_tbl[i])
            colour_tbl[i] = '0;
        px_done    = '0;
        chunk      = CK_RGB;
        bytes_left = '0;
        held       = '0;
        marker_pos = '0;
        stage      = PH_DECODE;
    endfunction

    function automatic void emit(input logic [1:0] k, input logic [31:0] px);
        byte_results.push_back({k, px, 1'b0});
    endfunction

    function automatic void set_px(input logic [7:0] r, input logic [7:0] g,
                                   input logic [7:0] bl, input logic [7:0] a);
        cur_px = {r, g, bl, a};
    endfunction

    // store in the colour table, then put out as many pixels as the image still has room for
    function automatic void complete_chunk(input int unsigned count);
        int unsigned sum;
        int unsigned remaining;
        sum = 3 * cur_px[31:24] + 5 * cur_px[23:16] + 7 * cur_px[15:8] + 11 * cur_px[7:0];
        colour_tbl[sum[5:0]] = cur_px;
        if (px_done < pixel_total)
            remaining = 32'(pixel_total - px_done);
        else
            remaining = 0;
        if (count > remaining)
            count = remaining;
        for (int i = 0; i < count; i++)
            emit(KIND_PIXEL, cur_px);
        px_done = PIXELS_W'(px_done + count);
    endfunction

    function automatic void decode_chunk_byte(input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] bl;
        logic [7:0] a;
        logic [7:0] dg;
        r  = cur_px[31:24];
        g  = cur_px[23:16];
        bl = cur_px[15:8];
        a  = cur_px[7:0];
        if (bytes_left != 0)
        begin
            if (chunk == CK_LUMA)
            begin
                dg = {2'b00, held[5:0]};
                bytes_left = '0;
                set_px(8'(r + dg - 8'd32 + {4'd0, b[7:4]} - 8'd8), 8'(g + dg - 8'd32),
                       8'(bl + dg - 8'd32 + {4'd0, b[3:0]} - 8'd8), a);
                complete_chunk(1);
            end
            else if (chunk == CK_RGBA && bytes_left == 1)
            begin
                bytes_left = '0;
                set_px(held[23:16], held[15:8], held[7:0], b);
                complete_chunk(1);
            end
            else
            begin
                held = {held[15:0], b};
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0)
                begin
                    set_px(held[23:16], held[15:8], held[7:0], a);
                    complete_chunk(1);
                end
            end
        end
        else if (b == TAG_RGB)
        begin
            chunk      = CK_RGB;
            bytes_left = 3'd3;
            held       = '0;
        end
        else if (b == TAG_RGBA)
        begin
            chunk      = CK_RGBA;
            bytes_left = 3'd4;
            held       = '0;
        end
        else if (b[7:6] == OP_INDEX)
        begin
            cur_px = colour_tbl[b[5:0]];
            complete_chunk(1);
        end
        else if (b[7:6] == OP_DIFF)
        begin
            // deltas carry a bias of 2
            set_px(8'(r + {6'd0, b[5:4]} - 8'd2), 8'(g + {6'd0, b[3:2]} - 8'd2),
                   8'(bl + {6'd0, b[1:0]} - 8'd2), a);
            complete_chunk(1);
        end
        else if (b[7:6] == OP_LUMA)
        begin
            chunk      = CK_LUMA;
            bytes_left = 3'd1;
            held       = {18'b0, b[5:0]};
        end
        else
        begin
            complete_chunk(b[5:0] + 1);
        end
    endfunction

    function automatic void decode_transfer(input logic [7:0] b, input logic sof,
                                            input logic last);
        byte_results.delete();
        if (sof)
            restart_image();
        // total already reached (or lowered): this byte belongs to the end marker
        if (stage == PH_DECODE && bytes_left == 0 && px_done >= pixel_total)
        begin
            stage      = PH_TRAILER;
            marker_pos = '0;
        end
        if (stage == PH_DECODE)
        begin
            decode_chunk_byte(b);
            if (bytes_left == 0 && px_done >= pixel_total)
            begin
                stage      = PH_TRAILER;
                marker_pos = '0;
            end
            if (last)
            begin
                emit(KIND_ERROR, '0);
                stage = PH_FINISHED;
            end
        end
        else if (stage == PH_TRAILER)
        begin
            if (b != ((marker_pos < MARKER_LAST) ? 8'h00 : 8'h01))
            begin
                emit(KIND_ERROR, '0);
                stage = PH_FINISHED;
            end
            else if (marker_pos >= MARKER_LAST)
            begin
                emit(last ? KIND_OK : KIND_ERROR, '0);
                stage = PH_FINISHED;
            end
            else if (last)
            begin
                emit(KIND_ERROR, '0);
                stage = PH_FINISHED;
            end
            else
            begin
                marker_pos = marker_pos + 1'b1;
            end
        end
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last = 1'b1;
        foreach (byte_results[i])
            awaited.push_back(byte_results[i]);
    endfunction

    function automatic void check_result();
        decoder_out_t seen;
        decoder_out_t want;
        seen = {kind, red, green, blue, alpha, last_of_run};
        if (awaited.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected result at %0t: kind %0d rgba %02h %02h %02h %02h last %0d",
                         $time, seen.kind, seen.red, seen.green, seen.blue, seen.alpha,
                         seen.last);
        end
        else
        begin
            want = awaited.pop_front();
            if (seen !== want)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("mismatch at %0t: expected kind %0d rgba %02h %02h %02h %02h last %0d",
                             $time, want.kind, want.red, want.green, want.blue, want.alpha,
                             want.last);
                    $display("    got kind %0d rgba %02h %02h %02h %02h last %0d",
                             seen.kind, seen.red, seen.green, seen.blue, seen.alpha,
                             seen.last);
                end
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pixel_total = PIXELS_W'(1);
            restart_image();
            awaited.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (pop && !empty)
                check_result();
            if (cfg_valid && cfg_ready)
                pixel_total = cfg_data;
            if (push && !full)
                decode_transfer(data_byte, start_of_image, last_byte);
            outstanding = awaited.size();
        end
    end

endmodule

// ----- test/tb_qoi_image_decoder.sv -----
`timescale 1ns / 1ps

module tb_qoi_image_decoder import qoi_pkg::*; ;

    localparam int                  CLK_HALF      = 6;
    localparam int                  CYCLE_LIMIT   = 1_500_000;
    localparam int                  RANDOM_ITEMS  = 300;
    localparam int                  SETTLE_CYCLES = 10;
    localparam int                  MAX_CHUNKS    = 40;
    localparam logic [1:0]          OP_RUN        = 2'b11;
    localparam logic [PIXELS_W-1:0] TOTAL_MAX     = 29'd400_000_000;
    localparam logic [PIXELS_W-1:0] TOTAL_LOW_ONES = 29'h0FFF_FFFF;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [7:0]          data_byte;
    logic                start_of_image;
    logic                last_byte;
    logic                pop;
    logic                empty;
    logic [1:0]          kind;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [7:0]          alpha;
    logic                last_of_run;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [PIXELS_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int cycle_count;
    int bytes_fed;
    int burst_left;

    qoi_image_decoder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .start_of_image (start_of_image),
        .last_byte      (last_byte),
        .pop            (pop),
        .empty          (empty),
        .kind           (kind),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .last_of_run    (last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    qoi_decode_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .start_of_image (start_of_image),
        .last_byte      (last_byte),
        .pop            (pop),
        .empty          (empty),
        .kind           (kind),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .alpha          (alpha),
        .last_of_run    (last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // result side: the stall pattern changes from one random span to the next
    initial
    begin
        int mode;
        int span;
        int tick;
        pop = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            tick = 0;
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 3) != 0);
                    2:       pop <= ($urandom_range(0, 3) == 0);
                    default: pop <= (tick >= span / 2);
                endcase
                tick++;
            end
        end
    end

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
        repeat (gap)
        begin
            @(negedge clk);
            push           <= 1'b0;
            data_byte      <= 8'($urandom_range(0, 255));
            start_of_image <= 1'($urandom_range(0, 1));
            last_byte      <= 1'($urandom_range(0, 1));
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 12);
    endtask

    // push stays high into the next call so back-to-back transfers need no drop
    task automatic feed_byte(input logic [7:0] b, input logic sof, input logic last);
        if (burst_left == 0)
            idle_gap();
        burst_left--;
        @(negedge clk);
        push           <= 1'b1;
        data_byte      <= b;
        start_of_image <= sof;
        last_byte      <= last;
        do @(posedge clk); while (full);
        bytes_fed++;
    endtask

    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_total(input logic [PIXELS_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= PIXELS_W'($urandom);
    endtask

    // one chunk with random content; cut_short ends the buffer somewhere inside it
    task automatic feed_chunk(input logic sof, input logic cut_short, output int pixels);
        logic [7:0] chunk_bytes [5];
        int         pick;
        int         len;
        int         run;
        int         stop;
        for (int i = 0; i < 5; i++)
            chunk_bytes[i] = 8'($urandom_range(0, 255));
        pick   = $urandom_range(0, 99);
        len    = 1;
        pixels = 1;
        if (pick < 12)
        begin
            chunk_bytes[0] = TAG_RGB;
            len = 4;
        end
        else if (pick < 22)
        begin
            chunk_bytes[0] = TAG_RGBA;
            len = 5;
        end
        else if (pick < 45)
            chunk_bytes[0] = {OP_INDEX, chunk_bytes[0][5:0]};
        else if (pick < 65)
            chunk_bytes[0] = {OP_DIFF, chunk_bytes[0][5:0]};
        else if (pick < 82)
        begin
            chunk_bytes[0] = {OP_LUMA, chunk_bytes[0][5:0]};
            len = 2;
        end
        else
        begin
            // run lengths of 63 and 64 would collide with the RGB/RGBA tags
            run = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 61);
            chunk_bytes[0] = {OP_RUN, 6'(run)};
            pixels = run + 1;
        end
        stop = cut_short ? $urandom_range(0, len - 1) : len - 1;
        for (int i = 0; i <= stop; i++)
            feed_byte(chunk_bytes[i], sof && (i == 0), cut_short && (i == stop));
    endtask

    task automatic feed_marker();
        int         flaw;
        int         spot;
        int         extra;
        logic [7:0] b;
        flaw = $urandom_range(0, 9);
        spot = $urandom_range(0, 7);
        for (int i = 0; i < 8; i++)
        begin
            b = (i == 7) ? 8'h01 : 8'h00;
            if (flaw == 6 && i == spot)
                b = b ^ 8'($urandom_range(1, 255));
            feed_byte(b, 1'b0, (flaw == 7) ? (i == spot) : (i == 7 && flaw != 8));
            if (flaw == 7 && i == spot)
                break;
        end
        // bytes after the verdict are dropped and do not count
        if (flaw >= 8)
        begin
            extra = $urandom_range(1, 3);
            repeat (extra)
                feed_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            bytes_fed -= extra;
        end
    endtask

    task automatic feed_image(input int image_no);
        logic [PIXELS_W-1:0] total;
        logic                fresh;
        int                  pick;
        int                  px;
        int                  fed_px;
        int                  chunks;
        pick = $urandom_range(0, 9);
        if (image_no == 0)
            total = TOTAL_MAX;
        else if (image_no == 1)
            total = TOTAL_LOW_ONES;
        else if (pick == 0)
            total = PIXELS_W'(1);
        else if (pick == 1)
            total = PIXELS_W'($urandom_range(1, TOTAL_MAX));
        else
            total = PIXELS_W'($urandom_range(2, 40));
        settle();
        set_total(total);
        fed_px = 0;
        chunks = 0;
        while (fed_px < total && chunks < MAX_CHUNKS)
        begin
            if (chunks > 0 && $urandom_range(0, 39) == 0)
            begin
                feed_chunk(1'b0, 1'b1, px);
                return;
            end
            fresh = (chunks == 0) || ($urandom_range(0, 49) == 0);
            if (fresh)
                fed_px = 0;
            feed_chunk(fresh, 1'b0, px);
            fed_px += px;
            chunks++;
            // total lowered to at most the pixels already out: next byte is marker
            if (fed_px > 1 && fed_px < total && $urandom_range(0, 24) == 0)
            begin
                settle();
                total = PIXELS_W'($urandom_range(1, fed_px));
                set_total(total);
            end
        end
        if (fed_px < total)
            feed_chunk(1'b0, 1'b1, px);
        else
            feed_marker();
    endtask

    initial
    begin
        int target;
        rst_n          = 1'b0;
        push           = 1'b0;
        data_byte      = '0;
        start_of_image = 1'b0;
        last_byte      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        bytes_fed      = 0;
        burst_left     = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // every chunk type except RGB, run clipped at the total, clean end marker
        set_total(29'd5);
        feed_byte(TAG_RGBA, 1'b1, 1'b0);
        feed_byte(8'h80, 1'b0, 1'b0);
        feed_byte(8'h00, 1'b0, 1'b0);
        feed_byte(8'hFF, 1'b0, 1'b0);
        feed_byte(8'h7F, 1'b0, 1'b0);
        feed_byte({OP_DIFF, 6'h00}, 1'b0, 1'b0);
        feed_byte({OP_LUMA, 6'h00}, 1'b0, 1'b0);
        feed_byte(8'hFF, 1'b0, 1'b0);
        feed_byte({OP_INDEX, 6'h3F}, 1'b0, 1'b0);
        feed_byte({OP_RUN, 6'd61}, 1'b0, 1'b0);
        repeat (7) feed_byte(8'h00, 1'b0, 1'b0);
        feed_byte(8'h01, 1'b0, 1'b1);
        feed_byte({OP_RUN, 6'd0}, 1'b0, 1'b0);
        settle();

        // buffer ends on the completing byte, then a bad marker byte
        set_total(29'd1);
        feed_byte(TAG_RGB, 1'b1, 1'b0);
        feed_byte(8'h12, 1'b0, 1'b0);
        feed_byte(8'h34, 1'b0, 1'b0);
        feed_byte(8'h56, 1'b0, 1'b1);
        feed_byte({OP_INDEX, 6'h00}, 1'b1, 1'b0);
        feed_byte(8'h01, 1'b0, 1'b0);

        target = bytes_fed + RANDOM_ITEMS;
        for (int n = 0; bytes_fed < target; n++)
            feed_image(n);
        settle();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
